[design/gwps_pkg.sv]
// gwps_pkg: shared types and constants for the grid wavefront phase step block
// cell record, register index codes, phase limits
// no dependencies
package gwps_pkg;

   localparam int CFG_W         = 10;
   localparam int PHASE_W       = 10;
   localparam int MAX_WIDTH_DEF = 512;
   localparam int PHASE_PERIOD  = 360;

   localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = CFG_W'(420);
   localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = CFG_W'(420);

   // last phase before the wrap to zero
   localparam logic signed [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_PERIOD - 1);

   typedef struct packed {
      logic                      wall;
      logic signed [PHASE_W-1:0] value;
      logic signed [PHASE_W-1:0] pending;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   localparam cell_type WALL_CELL = '{wall: 1'b1, value: '1, pending: '1};

   typedef enum logic [0:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

endpackage

[design/gwps_ram.sv]
// gwps_ram: generic single-write, single-read memory with registered read data
// read is read-first: a same-address write in the same cycle is not seen
// no dependencies
module gwps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/grid_wavefront_phase_step.sv]
// grid_wavefront_phase_step: one generation of a wavefront phase automaton on a raster stream
// a cell's result is computed once the cell below it is accepted
// throughput: one cell per cycle unless rsp_ready is low or clearing runs; line buffers are
// 1R1W rams read at accept; stencil resolved in the following cycle into an output register
// reset: control state cleared, then a pass over all MAX_WIDTH addresses writes wall cells
// into the line buffers with req_ready low; csr writes are taken throughout
module grid_wavefront_phase_step #(
   parameter int MAX_WIDTH = gwps_pkg::MAX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  gwps_pkg::csr_index_type              csr_index,
   input  logic [gwps_pkg::CFG_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_wall,
   input  logic signed [gwps_pkg::PHASE_W-1:0]  req_value,
   input  logic signed [gwps_pkg::PHASE_W-1:0]  req_pending,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_wall,
   output logic signed [gwps_pkg::PHASE_W-1:0]  rsp_value,
   output logic signed [gwps_pkg::PHASE_W-1:0]  rsp_pending,
   output logic                                 rsp_last
);
   import gwps_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW    = $clog2(MAX_WIDTH + 1);

   typedef struct packed {
      logic             active;     // row counter above zero: a result is due
      logic [COL_W-1:0] col;
      logic             col_is0;
      logic             row_is1;
      logic             down_wall;  // flush row or beyond
      logic             right_ok;
      logic             last;
      logic             up_fwd;
      cell_type         up_fwd_cell;
      cell_type         inc;
   } stage_type;

   function automatic logic [EW-1:0] sat_width(logic [CFG_W-1:0] raw);
      logic [31:0] v;
      v = 32'(raw);
      if (v == 32'd0) begin
         v = 32'd1;
      end else if (v > 32'(MAX_WIDTH)) begin
         v = 32'(MAX_WIDTH);
      end
      return EW'(v);
   endfunction

   function automatic logic [CFG_W-1:0] sat_height(logic [CFG_W-1:0] raw);
      return (raw == '0) ? CFG_W'(1) : raw;
   endfunction

   function automatic logic signed [PHASE_W-1:0] lit_value(cell_type n);
      return (!n.wall && !n.value[PHASE_W-1]) ? n.value : '1;
   endfunction

   function automatic logic signed [PHASE_W-1:0] smax(logic signed [PHASE_W-1:0] a,
                                                      logic signed [PHASE_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // configuration
   logic [EW-1:0]    width_ff;
   logic [CFG_W-1:0] height_ff;

   // counters and clearing pass
   logic [COL_W-1:0] col_ff, col_in;
   logic [CFG_W-1:0] row_ff, row_in;
   logic             clr_busy_ff;
   logic [COL_W-1:0] clr_addr_ff;

   // stencil stage
   logic      s1_valid_ff;
   stage_type s1_ff, s1_in;
   cell_type  left_ff;

   // output register
   logic                      rsp_valid_ff;
   logic                      rsp_wall_ff;
   logic signed [PHASE_W-1:0] rsp_value_ff;
   logic signed [PHASE_W-1:0] rsp_pending_ff;
   logic                      rsp_last_ff;

   logic accept, s1_adv, out_load, above_wr;
   logic [31:0] col_next;

   logic [CELL_W-1:0] mid_rdata, right_rdata, above_rdata;
   cell_type          inc, centre, nb_right, nb_up, nb_down, nb_left;
   logic signed [PHASE_W-1:0] best, new_value, new_pending;

   logic             mem_wr_en;
   logic [COL_W-1:0] mem_wr_addr;
   cell_type         mem_wr_cell;
   logic             abv_wr_en;
   logic [COL_W-1:0] abv_wr_addr;
   cell_type         abv_wr_cell;

   assign inc = '{wall: req_wall, value: req_value, pending: req_pending};

   // handshake flow
   assign out_load  = s1_valid_ff && s1_ff.active && (!rsp_valid_ff || rsp_ready);
   assign s1_adv    = !s1_ff.active || out_load;
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;
   assign above_wr  = s1_valid_ff && s1_ff.active && s1_adv;

   // raster position of the incoming transaction
   assign col_next = 32'(col_ff) + 32'd1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= 32'(width_ff)) begin
            col_in = '0;
            row_in = (row_ff >= height_ff) ? '0 : row_ff + CFG_W'(1);
         end else begin
            col_in = COL_W'(col_next);
         end
      end
   end

   always_comb begin
      s1_in.active      = (row_ff != '0);
      s1_in.col         = col_ff;
      s1_in.col_is0     = (col_ff == '0);
      s1_in.row_is1     = (row_ff == CFG_W'(1));
      s1_in.down_wall   = (row_ff >= height_ff);
      s1_in.right_ok    = (col_next < 32'(width_ff));
      s1_in.last        = (row_ff == height_ff) && (col_next == 32'(width_ff));
      // the above-row write of the cell in the stencil stage lands at this edge
      s1_in.up_fwd      = s1_valid_ff && s1_ff.active && (s1_ff.col == col_ff);
      s1_in.up_fwd_cell = centre;
      s1_in.inc         = inc;
   end

   // memory write ports, shared with the clearing pass
   always_comb begin
      mem_wr_en   = clr_busy_ff || accept;
      mem_wr_addr = clr_busy_ff ? clr_addr_ff : col_ff;
      mem_wr_cell = clr_busy_ff ? WALL_CELL : inc;
      abv_wr_en   = clr_busy_ff || above_wr;
      abv_wr_addr = clr_busy_ff ? clr_addr_ff : s1_ff.col;
      abv_wr_cell = clr_busy_ff ? WALL_CELL : centre;
   end

   // middle row, read at the current column
   gwps_ram #(.WIDTH(CELL_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_cell),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (mid_rdata)
   );

   // copy of the middle row, read one column ahead for the right neighbor
   gwps_ram #(.WIDTH(CELL_W), .DEPTH(MAX_WIDTH)) u_right_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_cell),
      .rd_en   (accept),
      .rd_addr (COL_W'(col_next)),
      .rd_data (right_rdata)
   );

   gwps_ram #(.WIDTH(CELL_W), .DEPTH(MAX_WIDTH)) u_above_ram (
      .clock   (clock),
      .wr_en   (abv_wr_en),
      .wr_addr (abv_wr_addr),
      .wr_data (abv_wr_cell),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above_rdata)
   );

   // cross stencil and update rule
   always_comb begin
      centre   = cell_type'(mid_rdata);
      nb_right = s1_ff.right_ok ? cell_type'(right_rdata) : WALL_CELL;
      nb_up    = s1_ff.row_is1 ? WALL_CELL
               : (s1_ff.up_fwd ? s1_ff.up_fwd_cell : cell_type'(above_rdata));
      nb_down  = s1_ff.down_wall ? WALL_CELL : s1_ff.inc;
      nb_left  = s1_ff.col_is0 ? WALL_CELL : left_ff;
      best     = smax(smax(lit_value(nb_right), lit_value(nb_down)),
                      smax(lit_value(nb_up), lit_value(nb_left)));
      if (centre.wall) begin
         new_value   = centre.value;
         new_pending = centre.pending;
      end else if (!centre.value[PHASE_W-1]) begin
         new_value   = (centre.value >= PHASE_LAST) ? '0 : centre.value + PHASE_W'(1);
         new_pending = new_value;
      end else begin
         // no lit open neighbor leaves best at -1
         new_value   = best[PHASE_W-1] ? centre.pending : best;
         new_pending = new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sat_width(GRID_WIDTH_RST);
         height_ff <= sat_height(GRID_HEIGHT_RST);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_GRID_WIDTH:  width_ff  <= sat_width(csr_wdata);
            CSR_GRID_HEIGHT: height_ff <= sat_height(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + COL_W'(1);
            if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (above_wr) begin
         left_ff <= centre;
      end
      if (out_load) begin
         rsp_wall_ff    <= centre.wall;
         rsp_value_ff   <= new_value;
         rsp_pending_ff <= new_pending;
         rsp_last_ff    <= s1_ff.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_wall    = rsp_wall_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_pending = rsp_pending_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

[design/gwps_checker.sv]
// gwps_checker: port-level assertions for grid_wavefront_phase_step
// bound to the top level below; uses gwps_pkg for field widths
module gwps_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_wall,
   input logic signed [gwps_pkg::PHASE_W-1:0]  rsp_value,
   input logic signed [gwps_pkg::PHASE_W-1:0]  rsp_pending,
   input logic                                 rsp_last
);
   import gwps_pkg::*;

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wall) && $stable(rsp_value)
                                  && $stable(rsp_pending) && $stable(rsp_last))
      else $error("stalled result changed");

   // line buffer clearing keeps the input closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("block open right after reset");

   // open cells leave with pending equal to the new phase
   a_open_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wall |-> rsp_value == rsp_pending)
      else $error("open cell pending differs from value");

   // a fresh result follows an input transaction that passed the stencil and output registers
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without an earlier input transaction");

endmodule

bind grid_wavefront_phase_step gwps_checker u_gwps_checker (.*);
